/* src/cbf_pkg.sv */
// Shared constants for the cubic Bezier flattener.
`timescale 1ns / 1ps
package cbf_pkg;

  localparam int COORD_BITS_DEFAULT = 16;
  localparam int STEPS_DEFAULT      = 15;
  localparam int T_BITS             = 16;
  localparam int LERP_LATENCY       = 2;

endpackage

/* src/cbf_lerp.sv */
// Two-stage linear interpolation a + floor((b - a) * t / 2^16) with registered product.
`timescale 1ns / 1ps
module cbf_lerp #(
  parameter int COORD_BITS = cbf_pkg::COORD_BITS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [COORD_BITS-1:0] a,
  input  logic signed [COORD_BITS-1:0] b,
  input  logic [cbf_pkg::T_BITS-1:0]   t,
  output logic signed [COORD_BITS-1:0] y
);

  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = DIFF_W + cbf_pkg::T_BITS + 1;

  logic signed [DIFF_W-1:0]     diff;
  logic signed [PROD_W-1:0]     prod_next;
  logic signed [PROD_W-1:0]     prod;
  logic signed [COORD_BITS-1:0] base;
  logic signed [PROD_W-1:0]     quot;
  logic signed [PROD_W-1:0]     sum;

  assign diff      = DIFF_W'(b) - DIFF_W'(a);
  assign prod_next = PROD_W'(diff) * PROD_W'($signed({1'b0, t}));
  assign quot      = prod >>> cbf_pkg::T_BITS;
  assign sum       = PROD_W'(base) + quot;

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= prod_next;
      base <= a;
      y    <= sum[COORD_BITS-1:0];
    end
  end

endmodule

/* src/cubic_bezier_flattener_top.sv */
// Top level of the cubic Bezier flattener: segment register, sample sequencer and lerp pipeline.
`timescale 1ns / 1ps
// Each accepted segment word yields STEPS curve points at t = k/STEPS, plus the end point
// when s_tlast (curve_end) is set, one point per cycle on the master side while m_tready
// does not stall; the next segment is taken while the last point of the current one is
// issued. Points pass through a seven-stage pipeline (issue register, then three levels
// of two-stage interpolation, the last of which is the output register). A stall on
// m_tready holds the whole pipeline.
module cubic_bezier_flattener_top #(
  parameter int STEPS      = cbf_pkg::STEPS_DEFAULT,
  parameter int COORD_BITS = cbf_pkg::COORD_BITS_DEFAULT
) (
  input  logic                                    clk,
  input  logic                                    rst,
  // start_x, start_y, handle_a_x, handle_a_y, handle_b_x, handle_b_y, end_x, end_y
  input  logic [8*COORD_BITS-1:0]                 s_tdata,
  input  logic                                    s_tlast,
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  // point_x, point_y, zero padding to whole bytes
  output logic [((2*COORD_BITS+7)/8)*8-1:0]       m_tdata,
  output logic                                    m_tlast,
  output logic                                    m_tvalid,
  input  logic                                    m_tready
);

  localparam int KW    = $clog2(STEPS + 1);
  localparam int OUT_W = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int TB    = cbf_pkg::T_BITS;
  localparam int DEPTH = 1 + 3 * cbf_pkg::LERP_LATENCY;

  logic [TB-1:0] t_table [2**KW];

  for (genvar g = 0; g < 2**KW; g++) begin : g_ttab
    if (g < STEPS) begin : g_used
      localparam longint TV = (longint'(g) * (longint'(1) << TB) + STEPS / 2) / STEPS;
      assign t_table[g] = TV[TB-1:0];
    end else begin : g_spare
      assign t_table[g] = '0;
    end
  end

  logic                         seg_valid;
  logic                         seg_end;
  logic signed [COORD_BITS-1:0] seg_x [4];
  logic signed [COORD_BITS-1:0] seg_y [4];
  logic [KW-1:0]                k;
  logic                         seg_last;
  logic                         adv;
  logic                         take;

  logic signed [COORD_BITS-1:0] px [4];
  logic signed [COORD_BITS-1:0] py [4];
  logic [DEPTH-1:0]             vpipe;
  logic [DEPTH-1:0]             lpipe;
  logic [TB-1:0]                tpipe [2 * cbf_pkg::LERP_LATENCY + 1];

  logic signed [COORD_BITS-1:0] l1x [3];
  logic signed [COORD_BITS-1:0] l1y [3];
  logic signed [COORD_BITS-1:0] l2x [2];
  logic signed [COORD_BITS-1:0] l2y [2];
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;

  assign adv      = !vpipe[DEPTH-1] || m_tready;
  assign seg_last = seg_end ? (k == KW'(STEPS)) : (k == KW'(STEPS - 1));
  assign s_tready = !seg_valid || (adv && seg_last);
  assign take     = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_valid <= 1'b0;
      k         <= '0;
    end else begin
      if (take) begin
        seg_valid <= 1'b1;
        k         <= '0;
      end else if (adv && seg_valid) begin
        if (seg_last) begin
          seg_valid <= 1'b0;
        end
        k <= k + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      seg_end <= s_tlast;
      for (int i = 0; i < 4; i++) begin
        seg_x[i] <= s_tdata[2*i*COORD_BITS +: COORD_BITS];
        seg_y[i] <= s_tdata[(2*i+1)*COORD_BITS +: COORD_BITS];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (adv) begin
      vpipe <= {vpipe[DEPTH-2:0], seg_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lpipe    <= {lpipe[DEPTH-2:0], seg_last};
      tpipe[0] <= t_table[k];
      for (int i = 1; i < 2 * cbf_pkg::LERP_LATENCY + 1; i++) begin
        tpipe[i] <= tpipe[i-1];
      end
      for (int i = 0; i < 4; i++) begin
        if (seg_end && k == KW'(STEPS)) begin
          px[i] <= seg_x[3];
          py[i] <= seg_y[3];
        end else begin
          px[i] <= seg_x[i];
          py[i] <= seg_y[i];
        end
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_l1
    cbf_lerp #(.COORD_BITS(COORD_BITS)) u_lx (
      .clk(clk), .en(adv), .a(px[i]), .b(px[i+1]), .t(tpipe[0]), .y(l1x[i])
    );
    cbf_lerp #(.COORD_BITS(COORD_BITS)) u_ly (
      .clk(clk), .en(adv), .a(py[i]), .b(py[i+1]), .t(tpipe[0]), .y(l1y[i])
    );
  end

  for (genvar i = 0; i < 2; i++) begin : g_l2
    cbf_lerp #(.COORD_BITS(COORD_BITS)) u_lx (
      .clk(clk), .en(adv), .a(l1x[i]), .b(l1x[i+1]),
      .t(tpipe[cbf_pkg::LERP_LATENCY]), .y(l2x[i])
    );
    cbf_lerp #(.COORD_BITS(COORD_BITS)) u_ly (
      .clk(clk), .en(adv), .a(l1y[i]), .b(l1y[i+1]),
      .t(tpipe[cbf_pkg::LERP_LATENCY]), .y(l2y[i])
    );
  end

  cbf_lerp #(.COORD_BITS(COORD_BITS)) u_l3x (
    .clk(clk), .en(adv), .a(l2x[0]), .b(l2x[1]),
    .t(tpipe[2 * cbf_pkg::LERP_LATENCY]), .y(point_x)
  );
  cbf_lerp #(.COORD_BITS(COORD_BITS)) u_l3y (
    .clk(clk), .en(adv), .a(l2y[0]), .b(l2y[1]),
    .t(tpipe[2 * cbf_pkg::LERP_LATENCY]), .y(point_y)
  );

  assign m_tdata  = OUT_W'({point_y, point_x});
  assign m_tlast  = lpipe[DEPTH-1];
  assign m_tvalid = vpipe[DEPTH-1];

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    seg_valid |-> (k <= KW'(STEPS)))
    else $error("sample counter ran past the end of the segment");

  a_idle_ready: assert property (@(posedge clk) disable iff (rst)
    !seg_valid |-> s_tready)
    else $error("input not ready while no segment is held");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> ($stable(vpipe) && $stable(m_tdata) && $stable(m_tlast)))
    else $error("pipeline moved while the output word was stalled");

  a_end_after_last: assert property (@(posedge clk) disable iff (rst)
    (seg_valid && adv && seg_last && !take) |=> !seg_valid)
    else $error("segment held after its last point was issued");

endmodule

/* tb/cbf_point_checker.sv */
// Checker for the cubic Bezier flattener: predicts the curve points of each segment word and compares them.
`timescale 1ns / 1ps
module cbf_point_checker #(
  parameter int STEPS      = cbf_pkg::STEPS_DEFAULT,
  parameter int COORD_BITS = cbf_pkg::COORD_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [8*COORD_BITS-1:0]             s_tdata,
  input  logic                                s_tlast,
  input  logic                                s_tvalid,
  input  logic                                s_tready,
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]   m_tdata,
  input  logic                                m_tlast,
  input  logic                                m_tvalid,
  input  logic                                m_tready,
  output int                                  fail_count,
  output int                                  pending_points,
  output int                                  segments_seen,
  output int                                  points_seen
);

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic                  last;
  } curve_point_t;

  curve_point_t expected_points[$];

  initial begin
    fail_count     = 0;
    pending_points = 0;
    segments_seen  = 0;
    points_seen    = 0;
  end

  // One interpolation step: a + floor((b - a) * t / 2^16).
  function automatic longint lerp_fixed(longint a, longint b, longint t);
    longint prod;
    prod = (b - a) * t;
    return a + (prod >>> cbf_pkg::T_BITS);
  endfunction

  function automatic longint casteljau_axis(longint p0, longint p1, longint p2, longint p3,
                                            longint t);
    longint a, b, c;
    a = lerp_fixed(p0, p1, t);
    b = lerp_fixed(p1, p2, t);
    c = lerp_fixed(p2, p3, t);
    return lerp_fixed(lerp_fixed(a, b, t), lerp_fixed(b, c, t), t);
  endfunction

  task automatic predict_segment(input logic [8*COORD_BITS-1:0] word, input logic curve_end);
    longint       c[8];
    longint       t;
    curve_point_t p;
    for (int i = 0; i < 8; i++) c[i] = longint'($signed(word[i*COORD_BITS +: COORD_BITS]));
    for (int k = 0; k < STEPS; k++) begin
      t      = (longint'(k) * (longint'(1) << cbf_pkg::T_BITS) + STEPS / 2) / STEPS;
      p.x    = COORD_BITS'(casteljau_axis(c[0], c[2], c[4], c[6], t));
      p.y    = COORD_BITS'(casteljau_axis(c[1], c[3], c[5], c[7], t));
      p.last = !curve_end && (k == STEPS - 1);
      expected_points = {expected_points, p};
    end
    if (curve_end) begin
      p.x    = COORD_BITS'(c[6]);
      p.y    = COORD_BITS'(c[7]);
      p.last = 1'b1;
      expected_points = {expected_points, p};
    end
  endtask

  task automatic check_point(input curve_point_t got);
    curve_point_t want;
    if (expected_points.size() == 0) begin
      if (fail_count < 10)
        $display("Point %0d arrived with nothing pending: x=%0d y=%0d last=%0b", points_seen,
                 $signed(got.x), $signed(got.y), got.last);
      fail_count++;
    end else begin
      want = expected_points.pop_front();
      if (got !== want) begin
        if (fail_count < 10)
          $display("Point %0d mismatch: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                   points_seen, $signed(want.x), $signed(want.y), want.last,
                   $signed(got.x), $signed(got.y), got.last);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        predict_segment(s_tdata, s_tlast);
        segments_seen++;
      end
      if (m_tvalid && m_tready) begin
        check_point({m_tdata[COORD_BITS-1:0], m_tdata[2*COORD_BITS-1:COORD_BITS], m_tlast});
        points_seen++;
      end
      pending_points = expected_points.size();
    end
  end

endmodule

/* tb/testbench.sv */
// Testbench top for the cubic Bezier flattener: segment stimulus, flow throttling and verdict.
`timescale 1ns / 1ps
module testbench;

  localparam int STEPS            = cbf_pkg::STEPS_DEFAULT;
  localparam int COORD_BITS       = cbf_pkg::COORD_BITS_DEFAULT;
  localparam int M_WIDTH          = ((2*COORD_BITS+7)/8)*8;
  localparam int CYCLE_LIMIT      = 400000;
  localparam int RANDOM_PER_PHASE = 95;
  localparam int HOLD_OFF_LENGTH  = 300;
  localparam int DRAIN_CYCLES     = 24;

  typedef logic [7:0][COORD_BITS-1:0] segment_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic [8*COORD_BITS-1:0] s_tdata = '0;
  logic                    s_tlast = 1'b0;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [M_WIDTH-1:0]      m_tdata;
  logic                    m_tlast;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;

  int stall_pct       = 0;
  int idle_pct        = 0;
  int hold_off_cycles = 0;
  int cycle_count     = 0;
  int fail_count, pending_points, segments_seen, points_seen;

  always #5 clk = ~clk;

  cubic_bezier_flattener_top #(.STEPS(STEPS), .COORD_BITS(COORD_BITS)) DUT (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tlast(s_tlast), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tlast(m_tlast), .m_tvalid(m_tvalid), .m_tready(m_tready)
  );

  cbf_point_checker #(.STEPS(STEPS), .COORD_BITS(COORD_BITS)) checker_inst (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tlast(s_tlast), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tlast(m_tlast), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .fail_count(fail_count), .pending_points(pending_points),
    .segments_seen(segments_seen), .points_seen(points_seen)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("cubic_bezier_flattener_top regression: fail");
      $finish;
    end
  end

  // The output side counts down a long hold-off on its own, otherwise it stalls at random.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        m_tready <= 1'b0;
        hold_off_cycles--;
      end else begin
        m_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic segment_t make_segment(logic [15:0] sx, sy, ax, ay, bx, by, ex, ey);
    segment_t seg;
    seg[0] = sx; seg[1] = sy; seg[2] = ax; seg[3] = ay;
    seg[4] = bx; seg[5] = by; seg[6] = ex; seg[7] = ey;
    return seg;
  endfunction

  function automatic segment_t random_segment();
    segment_t              seg;
    int                    mode;
    logic [COORD_BITS-1:0] base_x, base_y;
    mode   = $urandom_range(9);
    base_x = COORD_BITS'($urandom);
    base_y = COORD_BITS'($urandom);
    for (int i = 0; i < 8; i++) begin
      if (mode <= 5) begin
        seg[i] = COORD_BITS'($urandom);
      end else if (mode <= 7) begin
        // Short, gently curved segments around one spot, wrapping freely.
        seg[i] = ((i % 2) ? base_y : base_x) + COORD_BITS'($urandom_range(63)) - 16'd32;
      end else if (mode == 8) begin
        case ($urandom_range(3))
          0: seg[i] = 16'h8000;
          1: seg[i] = 16'h7fff;
          2: seg[i] = 16'h0000;
          default: seg[i] = 16'hffff;
        endcase
      end else begin
        seg[i] = (i % 2) ? base_y : base_x;
      end
    end
    return seg;
  endfunction

  task automatic offer_segment(input segment_t seg, input logic curve_end);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tdata  <= seg;
    s_tlast  <= curve_end;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_points();
    s_tvalid <= 1'b0;
    while (pending_points != 0) @(negedge clk);
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    offer_segment(make_segment(16'h0000, 16'h0000, 16'h0000, 16'h0000,
                               16'h0000, 16'h0000, 16'h0000, 16'h0000), 1'b0);
    offer_segment(make_segment(16'h0000, 16'h0000, 16'h0000, 16'h0000,
                               16'h0000, 16'h0000, 16'h0000, 16'h0000), 1'b1);
    offer_segment(make_segment(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                               16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff), 1'b1);
    offer_segment(make_segment(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                               16'h8000, 16'h8000, 16'h8000, 16'h8000), 1'b0);
    offer_segment(make_segment(16'h8000, 16'h7fff, 16'h7fff, 16'h8000,
                               16'h8000, 16'h7fff, 16'h7fff, 16'h8000), 1'b1);
    offer_segment(make_segment(16'h8000, 16'h7fff, 16'h7fff, 16'h8000,
                               16'h8000, 16'h7fff, 16'h7fff, 16'h8000), 1'b0);
    offer_segment(make_segment(16'h7fff, 16'h8000, 16'h8000, 16'h7fff,
                               16'h7fff, 16'h8000, 16'h8000, 16'h7fff), 1'b1);
    offer_segment(make_segment(16'h0000, 16'h0000, 16'h1555, 16'heaab,
                               16'h2aab, 16'hd555, 16'h4000, 16'hc000), 1'b1);
    offer_segment(make_segment(16'h5555, 16'haaaa, 16'h5555, 16'haaaa,
                               16'h5555, 16'haaaa, 16'h5555, 16'haaaa), 1'b0);
    offer_segment(make_segment(16'haaaa, 16'h5555, 16'haaaa, 16'h5555,
                               16'haaaa, 16'h5555, 16'haaaa, 16'h5555), 1'b1);
    offer_segment(make_segment(16'hffff, 16'hffff, 16'hffff, 16'hffff,
                               16'hffff, 16'hffff, 16'hffff, 16'hffff), 1'b1);
    offer_segment(make_segment(16'h0001, 16'h0001, 16'h0001, 16'h0001,
                               16'h0001, 16'h0001, 16'h0001, 16'h0001), 1'b0);
    offer_segment(make_segment(16'h8000, 16'h8000, 16'h0000, 16'h0000,
                               16'h0000, 16'h0000, 16'h7fff, 16'h7fff), 1'b1);
    drain_points();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 50; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 50; hold_off_cycles = HOLD_OFF_LENGTH; end
        default: begin idle_pct = 18; stall_pct = 18; end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++)
        offer_segment(random_segment(), 1'($urandom_range(1)));
      drain_points();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d segments and %0d curve points over four throttling phases,",
             segments_seen, points_seen);
    $display("including a long output hold-off and a full drain after each phase.");
    if (fail_count == 0 && pending_points == 0)
      $display("cubic_bezier_flattener_top regression: pass");
    else
      $display("cubic_bezier_flattener_top regression: fail");
    $finish;
  end

endmodule

/* files.f */
src/cbf_pkg.sv
src/cbf_lerp.sv
src/cubic_bezier_flattener_top.sv
tb/cbf_point_checker.sv
tb/testbench.sv
